// File: design/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sprite frame sequencer
// Beat payloads, item and play mode codes, register indexes, the controller
// state type and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sfs_pkg;

	// input beat
	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] delta_time;
		logic [7:0]  frame_index;
		logic [31:0] delay_value;
	} item_t;

	// result beat
	typedef struct packed {
		logic [7:0] current_frame;
		logic       is_playing;
		logic       moving_backward;
	} result_t;

	// item codes
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_LOAD   = 3'd1;
	localparam logic [2:0] MODE_PLAY   = 3'd2;
	localparam logic [2:0] MODE_STOP   = 3'd3;
	localparam logic [2:0] MODE_REWIND = 3'd4;
	localparam logic [2:0] MODE_SEEK   = 3'd5;

	// play modes
	localparam logic [1:0] PLAY_LOOP   = 2'd0;
	localparam logic [1:0] PLAY_ONCE   = 2'd1;
	localparam logic [1:0] PLAY_BOUNCE = 2'd2;

	// register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd2;

	localparam logic [15:0] SPEED_RESET = 16'd256;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ACC,
		ST_SUM,
		ST_HOLD_RD,
		ST_HOLD,
		ST_DIV,
		ST_WALK_RD,
		ST_WALK,
		ST_DONE
	} seq_state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic mul;
		logic acc_upd;
		logic sum_clr;
		logic sum_step;
		logic div_start_sum;
		logic div_start_hold;
		logic div_step;
		logic div_end;
		logic walk_step;
		logic result_load;
	} seq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] item_mode;
		logic [1:0] play_mode;
		logic       tick_skip;
		logic       sum_done;
		logic       div_done;
		logic       walk_more;
		logic       result_free;
	} seq_status_t;

endpackage

// File: design/sprite_frame_sequencer_unit.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit: animation frame sequencer
// Steps through sprite frames on time ticks using a loadable delay table,
// in loop, play-once or bounce mode, with play, stop, rewind and seek items.
//
//   channel  direction  handshake             payload
//   item     in         item_valid/stall      item_t (mode, delta_time, ...)
//   result   out        result_valid/stall    result_t (frame, playing, back)
//   cfg      in         cfg_valid/ready       cfg_index, cfg_data
//
// One item at a time. Load, play, stop, rewind, seek and skipped ticks go
// from execute straight to the result hand-off. A play-once tick reads the
// frame's delay and then runs the divider. A loop or bounce tick with n frames
// in use and s frame steps does one delay-table read a cycle for the sum, then
// the divider, then the s steps on the table's registered read port.
// Reset clears control state and the result valid flag; the table is not cleared.
// A stalled result holds in its register while the next item is taken.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit
	import sfs_pkg::*;
#(
	parameter int unsigned MAX_FRAMES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	seq_cmd_t    cmd;
	seq_status_t status;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	sfs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	sfs_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_write    (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: design/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl: sequencing controller
// Walks each item through accept, execute, accumulate, table sum, divide,
// frame walk and result hand-off, issuing one command set per cycle.
// ----------------------------------------------------------------------------
module sfs_ctrl
	import sfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  seq_status_t status,
	output seq_cmd_t    cmd
);

	seq_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// take a new beat only when idle
	assign item_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.item_mode == MODE_TICK) begin
					if (status.tick_skip) begin
						state_d = ST_DONE;
					end else begin
						cmd.mul = 1'b1;
						state_d = ST_ACC;
					end
				end else begin
					cmd.exec = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_ACC: begin
				cmd.acc_upd = 1'b1;
				case (status.play_mode)
					PLAY_LOOP, PLAY_BOUNCE: begin
						cmd.sum_clr = 1'b1;
						state_d     = ST_SUM;
					end
					PLAY_ONCE: state_d = ST_HOLD_RD;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_SUM: begin
				if (status.sum_done) begin
					cmd.div_start_sum = 1'b1;
					state_d           = ST_DIV;
				end else begin
					cmd.sum_step = 1'b1;
				end
			end
			ST_HOLD_RD: state_d = ST_HOLD;
			ST_HOLD: begin
				cmd.div_start_hold = 1'b1;
				state_d            = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.div_end = 1'b1;
					state_d = (status.play_mode == PLAY_ONCE) ? ST_DONE : ST_WALK_RD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_WALK_RD: state_d = ST_WALK;
			ST_WALK: begin
				if (status.walk_more) begin
					cmd.walk_step = 1'b1;
					state_d       = ST_WALK_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.result_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: design/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath: registers, delay table and arithmetic of the sequencer
// Holds configuration, frame state and accumulator, the delay memory, a
// one-bit-per-cycle remainder divider and the result output register.
// ----------------------------------------------------------------------------
module sfs_datapath
	import sfs_pkg::*;
#(
	parameter int unsigned MAX_FRAMES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  item_t                 item,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  seq_cmd_t              cmd,
	output seq_status_t           status,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	localparam int unsigned DEPTH = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [8:0]  LIMIT = 9'(DEPTH);

	// configuration
	logic [1:0]  play_mode_q;
	logic [15:0] speed_q;
	logic [8:0]  fcount_q;

	// item and sequencer state
	item_t       item_q;
	logic [7:0]  frame_q;
	logic [31:0] acc_q;
	logic        bwd_q;
	logic        run_q;

	// arithmetic
	logic [47:0] prod_s1;
	logic [39:0] sum_q;
	logic [8:0]  cnt_q;
	logic        pend_q;
	logic [40:0] div_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [5:0]  dcnt_q;

	// delay table
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_q;
	logic [AW-1:0] rd_addr;

	// result
	result_t result_q;
	logic    result_valid_q;

	logic [8:0]  n_use;
	logic [8:0]  n_last;
	logic [31:0] hold_rd;
	logic [7:0]  walk_frame;
	logic        sum_issue;
	logic [40:0] acc_sum;
	logic [32:0] div_sh;
	logic        div_ge;
	logic [8:0]  frames_left;
	logic        once_end;
	logic        at_last;
	logic        load_ok;

	// frames in use and the last one
	assign n_use  = (fcount_q > LIMIT) ? LIMIT : fcount_q;
	assign n_last = n_use - 9'd1;

	// a zero delay holds for one unit
	assign hold_rd = (rd_q == 32'd0) ? 32'd1 : rd_q;

	// frame whose delay the next step uses
	always_comb begin
		walk_frame = frame_q;
		if (play_mode_q == PLAY_BOUNCE && bwd_q) begin
			walk_frame = (frame_q == 8'd0) ? n_last[7:0] : frame_q - 8'd1;
		end
	end

	assign sum_issue = (cnt_q < n_use);
	assign rd_addr   = cmd.sum_step ? cnt_q[AW-1:0] : walk_frame[AW-1:0];
	assign load_ok   = (32'(item_q.frame_index) < MAX_FRAMES);

	// saturating accumulate of the scaled time
	assign acc_sum = 41'(acc_q) + 41'(prod_s1[47:8]);

	// one restoring step of the divider
	assign div_sh = {rem_q, quo_q[31]};
	assign div_ge = ({8'd0, div_sh} >= div_q);

	assign frames_left = n_use - {1'b0, frame_q};
	assign once_end    = (quo_q >= 32'(frames_left));
	assign at_last     = (({1'b0, frame_q} + 9'd1) >= n_use);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_mode_q <= PLAY_LOOP;
			speed_q     <= SPEED_RESET;
			fcount_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PLAY_MODE:   play_mode_q <= cfg_data[1:0];
				REG_SPEED:       speed_q     <= cfg_data;
				REG_FRAME_COUNT: fcount_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// delay table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && item_q.mode == MODE_LOAD && load_ok) begin
			mem[item_q.frame_index[AW-1:0]] <= item_q.delay_value;
		end
		rd_q <= mem[rd_addr];
	end

	// hold the accepted item and the scaled time
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		if (cmd.mul) begin
			prod_s1 <= 48'(item_q.delta_time) * 48'(speed_q);
		end
	end

	// frame, accumulator, direction and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			acc_q   <= '0;
			bwd_q   <= 1'b0;
			run_q   <= 1'b1;
		end else begin
			if (cmd.exec) begin
				case (item_q.mode)
					MODE_PLAY: run_q <= 1'b1;
					MODE_STOP: run_q <= 1'b0;
					MODE_REWIND: begin
						frame_q <= '0;
						acc_q   <= '0;
					end
					MODE_SEEK: begin
						if ({1'b0, item_q.frame_index} < n_use) begin
							frame_q <= item_q.frame_index;
						end
					end
					default: ;
				endcase
			end
			if (cmd.acc_upd) begin
				acc_q <= (acc_sum[40:32] != 9'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];
				if ({1'b0, frame_q} >= n_use) begin
					frame_q <= n_last[7:0];
				end
			end
			if (cmd.div_end) begin
				if (play_mode_q == PLAY_ONCE) begin
					if (once_end) begin
						frame_q <= n_last[7:0];
						run_q   <= 1'b0;
						acc_q   <= '0;
					end else begin
						frame_q <= frame_q + quo_q[7:0];
						acc_q   <= rem_q;
					end
				end else begin
					acc_q <= rem_q;
				end
			end
			// step one frame, or turn around at an end in bounce mode
			if (cmd.walk_step) begin
				acc_q <= acc_q - hold_rd;
				if (play_mode_q == PLAY_BOUNCE) begin
					if (!bwd_q) begin
						if (at_last) begin
							bwd_q <= 1'b1;
						end else begin
							frame_q <= frame_q + 8'd1;
						end
					end else begin
						if (frame_q == 8'd0) begin
							bwd_q <= 1'b0;
						end else begin
							frame_q <= frame_q - 8'd1;
						end
					end
				end else begin
					frame_q <= at_last ? 8'd0 : frame_q + 8'd1;
				end
			end
		end
	end

	// sum of frame delays, one read a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.sum_clr) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.sum_step) begin
			if (sum_issue) begin
				cnt_q <= cnt_q + 9'd1;
			end
			pend_q <= sum_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_step && pend_q) begin
			sum_q <= sum_q + 40'(hold_rd);
		end
	end

	// remainder divider, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start_sum || cmd.div_start_hold) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start_sum) begin
			div_q <= (play_mode_q == PLAY_BOUNCE) ? {sum_q, 1'b0} : {1'b0, sum_q};
			quo_q <= acc_q;
			rem_q <= '0;
		end else if (cmd.div_start_hold) begin
			div_q <= 41'(hold_rd);
			quo_q <= acc_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[30:0], div_ge};
			rem_q <= div_ge ? 32'(41'(div_sh) - div_q) : div_sh[31:0];
		end
	end

	// result register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			result_q.current_frame   <= frame_q;
			result_q.is_playing      <= run_q;
			result_q.moving_backward <= bwd_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// status to the controller
	assign status.item_mode   = item_q.mode;
	assign status.play_mode   = play_mode_q;
	assign status.tick_skip   = !run_q || (n_use == 9'd0);
	assign status.sum_done    = !sum_issue && !pend_q;
	assign status.div_done    = (dcnt_q == 6'd32);
	assign status.walk_more   = (acc_q >= hold_rd);
	assign status.result_free = !result_valid_q || !result_stall;

endmodule

// File: verif/tb_sprite_frame_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer_unit: self-checking bench for the frame sequencer
// A directed table covers the edges: empty frame count, table loads at both
// ends, seek out of range, stop and play, rewind, and each play mode, with
// zero and full speed in bounce. Random phases then reprogram the registers while
// idle and drive ticks, loads, seeks and control items. A bit-accurate
// predictor fills in beats the table leaves open; a monitor checks all in order.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer_unit;
	import sfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_FRAMES   = 256;
	localparam int unsigned PHASES       = 22;
	localparam int unsigned QUIET_LIMIT  = 20000;
	localparam int unsigned DRAIN_CYCLES = 64;

	// codes the package does not name
	localparam logic [2:0]           MODE_RESV6  = 3'd6;
	localparam logic [2:0]           MODE_RESV7  = 3'd7;
	localparam logic [1:0]           PLAY_FROZEN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

	localparam logic FIXED_WANT = 1'b1;
	localparam logic PREDICT    = 1'b0;

	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		item_t                 beat;
		logic                  typed;
		result_t               want;
	} plan_row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// sequencer state as the block should hold it
	logic [31:0] hold_table [MAX_FRAMES];
	logic [7:0]  frame_now  = 8'd0;
	logic [31:0] time_acc   = 32'd0;
	logic        going_back = 1'b0;
	logic        running    = 1'b1;
	logic [1:0]  cfg_play   = PLAY_LOOP;
	logic [15:0] cfg_speed  = SPEED_RESET;
	logic [8:0]  cfg_frames = 9'd0;

	result_t     frames_due [$];
	plan_row_t   plan [$];
	result_t     due;
	result_t     predicted;
	logic        want_typed = 1'b0;
	result_t     want_res   = '0;
	logic        idling_on  = 1'b0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned fail_count = 0;

	sprite_frame_sequencer_unit #(
		.MAX_FRAMES(MAX_FRAMES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic int unsigned live_frames();
		int unsigned n;
		n = 32'(cfg_frames);
		if (n > MAX_FRAMES) n = MAX_FRAMES;
		if (n > 256) n = 256;
		return n;
	endfunction

	// a zero delay holds for one unit
	function automatic logic [31:0] hold_for(int unsigned i);
		logic [31:0] v;
		v = (i < MAX_FRAMES) ? hold_table[i] : 32'd0;
		return (v == 32'd0) ? 32'd1 : v;
	endfunction

	// going backward, a step pays the previous frame's delay
	function automatic logic [31:0] bounce_hold(int unsigned f, int unsigned n);
		if (!going_back) return hold_for(f);
		return hold_for((f == 0) ? n - 1 : f - 1);
	endfunction

	function automatic void run_tick(logic [31:0] dt);
		int unsigned n, f, i;
		logic [63:0] grown, cycle_len;
		logic [31:0] d, steps;
		n = live_frames();
		if (!running || n == 0) return;

		// accumulate scaled time, saturating
		grown = ({32'd0, dt} * {48'd0, cfg_speed}) >> 8;
		grown = grown + {32'd0, time_acc};
		time_acc = (grown > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];

		// pull a stray frame back into range
		if (frame_now >= n) frame_now = 8'(n - 1);
		f = 32'(frame_now);

		case (cfg_play)
			PLAY_LOOP: begin
				cycle_len = 64'd0;
				for (i = 0; i < n; i++) cycle_len = cycle_len + {32'd0, hold_for(i)};
				grown = {32'd0, time_acc} % cycle_len;
				time_acc = grown[31:0];
				d = hold_for(f);
				while (time_acc >= d) begin
					time_acc = time_acc - d;
					f = (f + 1 >= n) ? 0 : f + 1;
					d = hold_for(f);
				end
				frame_now = 8'(f);
			end
			PLAY_ONCE: begin
				// every step of this tick pays the starting frame's delay
				d = hold_for(f);
				steps = time_acc / d;
				if (steps >= n - f) begin
					frame_now = 8'(n - 1);
					running = 1'b0;
					time_acc = 32'd0;
				end else begin
					frame_now = 8'(f + steps);
					time_acc = time_acc - steps * d;
				end
			end
			PLAY_BOUNCE: begin
				cycle_len = 64'd0;
				for (i = 0; i < n; i++) cycle_len = cycle_len + {32'd0, hold_for(i)};
				cycle_len = cycle_len * 2;
				grown = {32'd0, time_acc} % cycle_len;
				time_acc = grown[31:0];
				d = bounce_hold(f, n);
				while (time_acc >= d) begin
					time_acc = time_acc - d;
					if (!going_back) begin
						if (f + 1 >= n) going_back = 1'b1;
						else f++;
					end else begin
						if (f == 0) going_back = 1'b0;
						else f--;
					end
					d = bounce_hold(f, n);
				end
				frame_now = 8'(f);
			end
			default: begin
				// frozen: time grows, frames stay
			end
		endcase
	endfunction

	function automatic result_t step_sequencer(item_t b);
		case (b.mode)
			MODE_TICK:   run_tick(b.delta_time);
			MODE_LOAD:   if (b.frame_index < MAX_FRAMES) hold_table[b.frame_index] = b.delay_value;
			MODE_PLAY:   running = 1'b1;
			MODE_STOP:   running = 1'b0;
			MODE_REWIND: begin
				frame_now = 8'd0;
				time_acc = 32'd0;
			end
			MODE_SEEK:   if (b.frame_index < live_frames()) frame_now = b.frame_index;
			default: begin
			end
		endcase
		return {frame_now, running, going_back};
	endfunction

	function automatic void write_shadow_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_PLAY_MODE:   cfg_play = val[1:0];
			REG_SPEED:       cfg_speed = val;
			REG_FRAME_COUNT: cfg_frames = val[8:0];
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic item_t make_beat(logic [2:0] mode, logic [31:0] dt, logic [7:0] idx,
		logic [31:0] dv);
		item_t b;
		b.mode = mode;
		b.delta_time = dt;
		b.frame_index = idx;
		b.delay_value = dv;
		return b;
	endfunction

	function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		plan = {plan, r};
	endfunction

	function automatic void plan_beat(item_t b, logic typed, result_t w);
		plan_row_t r;
		r = '0;
		r.beat = b;
		r.typed = typed;
		r.want = w;
		plan = {plan, r};
	endfunction

	function automatic logic [31:0] rand_elapsed();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_delay();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom;
			2: return $urandom_range(1, 16);
			default: return $urandom_range(1, 32'h0003_0000);
		endcase
	endfunction

	// present one item beat, optionally after a gap; returns on a falling edge
	task automatic send_beat(item_t b, logic typed, result_t w);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= b;
		item_valid <= 1'b1;
		want_typed = typed;
		want_res = w;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	// drop the item valid and hold until every result beat is in
	task automatic wait_idle();
		item_valid <= 1'b0;
		do @(negedge clk); while (frames_due.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (last) cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(logic [15:0] pm_word, logic [15:0] spd, logic [15:0] fc_word,
		bit spare);
		wait_idle();
		if (spare) write_reg(REG_SPARE, 16'($urandom), 1'b0);
		write_reg(REG_PLAY_MODE, pm_word, 1'b0);
		write_reg(REG_SPEED, spd, 1'b0);
		write_reg(REG_FRAME_COUNT, fc_word, 1'b1);
	endtask

	task automatic report_mismatch(string what);
		// keep the log short on a badly broken build
		if (fail_count < 200) $display("%0t ns mismatch: %s", $time, what);
		fail_count++;
	endtask

	// ------------------------------------------------------------------
	// monitor: retire result beats, then predict accepted items
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (frames_due.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing pending: %h", result));
				end else begin
					due = frames_due.pop_front();
					if (result.current_frame !== due.current_frame ||
							result.is_playing !== due.is_playing ||
							result.moving_backward !== due.moving_backward)
						report_mismatch($sformatf(
							"frame %0d want %0d, playing %b want %b, back %b want %b",
							result.current_frame, due.current_frame, result.is_playing,
							due.is_playing, result.moving_backward, due.moving_backward));
				end
			end
			if (item_valid && !item_stall) begin
				predicted = step_sequencer(item);
				frames_due = {frames_due, (want_typed ? want_res : predicted)};
			end
			if (cfg_valid && cfg_ready) write_shadow_reg(cfg_index, cfg_data);
		end
	end

	// result stall: random bursts while idling is on
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog: end the run if no channel moves a beat for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned ph, k, n, n_items, r;
		logic [1:0]  pm;
		logic [8:0]  fc;
		logic [15:0] pm_word, spd, fc_word;
		item_t       b;

		for (k = 0; k < MAX_FRAMES; k++) hold_table[k] = 32'd0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty frame count: ticks and seeks change nothing
		plan_beat(make_beat(MODE_TICK, 32'h0001_0000, 8'd0, 32'd0), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_SEEK, 32'd0, 8'd3, 32'd0), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		// table loads, zero delay and both ends of the index
		plan_beat(make_beat(MODE_LOAD, 32'd0, 8'd0, 32'd0), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_LOAD, 32'd0, 8'd1, 32'h0001_0000), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_LOAD, 32'd0, 8'd2, 32'h0002_0000), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_LOAD, 32'd0, 8'd3, 32'h0000_8000), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_LOAD, 32'd0, 8'd255, 32'hFFFF_FFFF), FIXED_WANT,
			{8'd0, 1'b1, 1'b0});
		// unknown modes, fields at both extremes
		plan_beat(make_beat(MODE_RESV6, 32'd0, 8'd0, 32'd0), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_RESV7, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF), FIXED_WANT,
			{8'd0, 1'b1, 1'b0});
		// loop over four frames, smallest and saturating ticks
		plan_reg(REG_FRAME_COUNT, 16'd4);
		plan_beat(make_beat(MODE_TICK, 32'd1, 8'd0, 32'd0), PREDICT, '0);
		plan_beat(make_beat(MODE_TICK, 32'hFFFF_FFFF, 8'd0, 32'd0), PREDICT, '0);
		plan_beat(make_beat(MODE_SEEK, 32'd0, 8'd3, 32'd0), FIXED_WANT, {8'd3, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_SEEK, 32'd0, 8'd4, 32'd0), FIXED_WANT, {8'd3, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_STOP, 32'd0, 8'd0, 32'd0), FIXED_WANT, {8'd3, 1'b0, 1'b0});
		plan_beat(make_beat(MODE_TICK, 32'h0001_0000, 8'd0, 32'd0), FIXED_WANT,
			{8'd3, 1'b0, 1'b0});
		plan_beat(make_beat(MODE_PLAY, 32'd0, 8'd0, 32'd0), FIXED_WANT, {8'd3, 1'b1, 1'b0});
		// shrink the frame count under the shown frame
		plan_reg(REG_FRAME_COUNT, 16'd2);
		plan_beat(make_beat(MODE_TICK, 32'd0, 8'd0, 32'd0), PREDICT, '0);
		plan_reg(REG_FRAME_COUNT, 16'd4);
		plan_beat(make_beat(MODE_REWIND, 32'd0, 8'd0, 32'd0), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		// play once past the end
		plan_reg(REG_PLAY_MODE, {14'd0, PLAY_ONCE});
		plan_beat(make_beat(MODE_TICK, 32'hFFFF_FFFF, 8'd0, 32'd0), FIXED_WANT,
			{8'd3, 1'b0, 1'b0});
		plan_beat(make_beat(MODE_PLAY, 32'd0, 8'd0, 32'd0), FIXED_WANT, {8'd3, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_REWIND, 32'd0, 8'd0, 32'd0), FIXED_WANT, {8'd0, 1'b1, 1'b0});
		plan_beat(make_beat(MODE_TICK, 32'h0001_8000, 8'd0, 32'd0), PREDICT, '0);
		// bounce, then zero and full speed, then the frozen mode
		plan_reg(REG_PLAY_MODE, {14'd0, PLAY_BOUNCE});
		plan_beat(make_beat(MODE_TICK, 32'h0004_0000, 8'd0, 32'd0), PREDICT, '0);
		plan_beat(make_beat(MODE_TICK, 32'h0001_0000, 8'd0, 32'd0), PREDICT, '0);
		plan_reg(REG_SPEED, 16'd0);
		plan_beat(make_beat(MODE_TICK, 32'hFFFF_FFFF, 8'd0, 32'd0), PREDICT, '0);
		plan_reg(REG_SPEED, 16'hFFFF);
		plan_beat(make_beat(MODE_TICK, 32'h0000_1234, 8'd0, 32'd0), PREDICT, '0);
		plan_reg(REG_PLAY_MODE, {14'd0, PLAY_FROZEN});
		plan_beat(make_beat(MODE_TICK, 32'h0002_0000, 8'd0, 32'd0), PREDICT, '0);
		plan_beat(make_beat(MODE_SEEK, 32'd0, 8'd1, 32'd0), PREDICT, '0);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				wait_idle();
				write_reg(plan[i].reg_idx, plan[i].reg_val, 1'b1);
			end else begin
				send_beat(plan[i].beat, plan[i].typed, plan[i].want);
			end
		end

		// fill the whole delay table so any frame count reads written entries
		idling_on = 1'b1;
		for (k = 0; k < MAX_FRAMES; k++)
			send_beat(make_beat(MODE_LOAD, $urandom, 8'(k), rand_delay()), PREDICT, '0);

		// random phases, each with its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			idling_on = (ph < PHASES - 4) && ($urandom_range(0, 9) < 7);
			pm = ($urandom_range(0, 9) == 0) ? PLAY_FROZEN : 2'($urandom_range(0, 2));
			case ($urandom_range(0, 5))
				0: spd = 16'd0;
				1: spd = 16'hFFFF;
				2: spd = SPEED_RESET;
				default: spd = 16'($urandom_range(1, 1024));
			endcase
			case (ph)
				4, 11: fc = 9'd256;
				7: fc = 9'($urandom_range(257, 511));
				14: fc = 9'd0;
				default: fc = 9'($urandom_range(1, 12));
			endcase
			// unused upper bits of the register words vary too
			pm_word = 16'($urandom);
			if ($urandom_range(0, 1) == 0) pm_word = '0;
			pm_word[1:0] = pm;
			fc_word = 16'($urandom);
			if ($urandom_range(0, 1) == 0) fc_word = '0;
			fc_word[8:0] = fc;
			program_regs(pm_word, spd, fc_word, ph == 3);

			n_items = (fc >= 9'd256) ? 12 : $urandom_range(20, 34);
			for (k = 0; k < n_items; k++) begin
				// now and then let the block drain completely
				if ($urandom_range(0, 49) == 0) wait_idle();
				r = $urandom_range(0, 99);
				b = make_beat(MODE_TICK, rand_elapsed(), 8'($urandom), $urandom);
				if (r < 60) begin
				end else if (r < 68) begin
					b.mode = MODE_LOAD;
					b.delay_value = rand_delay();
				end else if (r < 76) begin
					b.mode = MODE_SEEK;
					n = live_frames();
					if (n != 0 && $urandom_range(0, 4) != 0)
						b.frame_index = 8'($urandom_range(0, n - 1));
				end else if (r < 86) begin
					b.mode = MODE_PLAY;
				end else if (r < 90) begin
					b.mode = MODE_STOP;
				end else if (r < 95) begin
					b.mode = MODE_REWIND;
				end else begin
					b.mode = (r < 98) ? MODE_RESV6 : MODE_RESV7;
				end
				send_beat(b, PREDICT, '0);
			end
		end

		// drain and close
		idling_on = 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (frames_due.size() != 0)
			report_mismatch($sformatf("%0d result beats never arrived", frames_due.size()));
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
